### sv/sga_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the stick gesture arming block.
package sga_pkg;

	localparam int STICK_W   = 12;
	localparam int TOL_W     = 11;
	localparam int CNT_W     = 16;
	localparam int SW_W      = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	// Widened signed width for level +/- window sums; 5 * tolerance fits with room.
	localparam int SUM_W     = 16;
	// Window widths up to three times the tolerance.
	localparam int WIN_W     = 13;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [SW_W-1:0] SW_MIN = 2'd0;
	localparam logic [SW_W-1:0] SW_MAX = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_DWELL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_DISARM   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd6;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT    = 2'd0,
		MODE_STANDBY = 2'd1,
		MODE_RUNNING = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [STICK_W-1:0] yaw;
		logic signed [STICK_W-1:0] roll;
		logic signed [STICK_W-1:0] pitch;
		logic signed [STICK_W-1:0] throttle;
		logic [SW_W-1:0]           sw_a;
		logic [SW_W-1:0]           sw_b;
		logic [SW_W-1:0]           sw_c;
		logic [SW_W-1:0]           sw_d;
	} item_t;

	typedef struct packed {
		logic signed [STICK_W-1:0] low_level;
		logic signed [STICK_W-1:0] center_level;
		logic signed [STICK_W-1:0] high_level;
		logic [TOL_W-1:0]          tolerance;
		logic [CNT_W-1:0]          arm_dwell;
		logic [CNT_W-1:0]          run_disarm;
		logic [CNT_W-1:0]          idle_timeout;
	} cfg_t;

	// Stick conditions decoded from one item, consumed by the mode controller.
	typedef struct packed {
		logic sw_ok;     // switch A at an end, B, C and D at minimum
		logic centered;  // yaw, roll, pitch centered, throttle low
		logic gesture;   // arm/disarm gesture: yaw, pitch, throttle low, roll high
		logic run_ok;    // yaw, roll, pitch centered, throttle raised
		logic idle_ok;   // sticks roughly centered, throttle at the bottom
	} gest_t;

	// True when v lies strictly inside lvl - w .. lvl + w.
	function automatic logic near_lvl(input logic signed [STICK_W-1:0] v,
			input logic signed [STICK_W-1:0] lvl, input logic [WIN_W-1:0] w);
		logic signed [SUM_W-1:0] vx;
		logic signed [SUM_W-1:0] lx;
		logic signed [SUM_W-1:0] wx;
		vx = SUM_W'(v);
		lx = SUM_W'(lvl);
		wx = signed'({{(SUM_W-WIN_W){1'b0}}, w});
		return (vx < lx + wx) && (vx > lx - wx);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

### sv/sga_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for stick items and mode results.
interface sga_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [sga_pkg::STICK_W-1:0]      yaw_stick;
	logic signed [sga_pkg::STICK_W-1:0]      roll_stick;
	logic signed [sga_pkg::STICK_W-1:0]      pitch_stick;
	logic signed [sga_pkg::STICK_W-1:0]      throttle_stick;
	logic [sga_pkg::SW_W-1:0]                switch_a_pos;
	logic [sga_pkg::SW_W-1:0]                switch_b_pos;
	logic [sga_pkg::SW_W-1:0]                switch_c_pos;
	logic [sga_pkg::SW_W-1:0]                switch_d_pos;

	modport source (output valid, yaw_stick, roll_stick, pitch_stick, throttle_stick,
		switch_a_pos, switch_b_pos, switch_c_pos, switch_d_pos, input ready);
	modport sink (input valid, yaw_stick, roll_stick, pitch_stick, throttle_stick,
		switch_a_pos, switch_b_pos, switch_c_pos, switch_d_pos, output ready);
endinterface

interface sga_out_if;
	logic                            valid;
	logic                            ready;
	logic [sga_pkg::MODE_W-1:0]      system_mode;
	logic                            prepared_flag;

	modport source (output valid, system_mode, prepared_flag, input ready);
	modport sink (input valid, system_mode, prepared_flag, output ready);
endinterface

### sv/sga_gesture_dec.sv
`timescale 1ns / 1ps
// Window comparisons that turn one registered stick item into gesture flags.
module sga_gesture_dec (
	input  sga_pkg::item_t item,
	input  sga_pkg::cfg_t  cfg,
	output sga_pkg::gest_t gest
);

	logic [sga_pkg::WIN_W-1:0] tol1;
	logic [sga_pkg::WIN_W-1:0] tol3;
	logic signed [sga_pkg::SUM_W-1:0] thr_x;
	logic signed [sga_pkg::SUM_W-1:0] low_x;
	logic signed [sga_pkg::SUM_W-1:0] tol_x;
	logic signed [sga_pkg::SUM_W-1:0] tol5_x;
	logic mid3;
	logic mid3_wide;
	logic thr_low;

	always_comb begin
		tol1   = sga_pkg::WIN_W'(cfg.tolerance);
		tol3   = sga_pkg::WIN_W'({cfg.tolerance, 1'b0}) + tol1;
		thr_x  = sga_pkg::SUM_W'(item.throttle);
		low_x  = sga_pkg::SUM_W'(cfg.low_level);
		tol_x  = signed'(sga_pkg::SUM_W'(cfg.tolerance));
		tol5_x = signed'(sga_pkg::SUM_W'({cfg.tolerance, 2'b00})) + tol_x;

		mid3 = sga_pkg::near_lvl(item.yaw, cfg.center_level, tol1)
			&& sga_pkg::near_lvl(item.roll, cfg.center_level, tol1)
			&& sga_pkg::near_lvl(item.pitch, cfg.center_level, tol1);
		mid3_wide = sga_pkg::near_lvl(item.yaw, cfg.center_level, tol3)
			&& sga_pkg::near_lvl(item.roll, cfg.center_level, tol3)
			&& sga_pkg::near_lvl(item.pitch, cfg.center_level, tol3);
		thr_low = sga_pkg::near_lvl(item.throttle, cfg.low_level, tol1);

		gest.sw_ok = ((item.sw_a == sga_pkg::SW_MIN) || (item.sw_a == sga_pkg::SW_MAX))
			&& (item.sw_b == sga_pkg::SW_MIN) && (item.sw_c == sga_pkg::SW_MIN)
			&& (item.sw_d == sga_pkg::SW_MIN);
		gest.centered = mid3 && thr_low;
		gest.gesture  = sga_pkg::near_lvl(item.yaw, cfg.low_level, tol1)
			&& sga_pkg::near_lvl(item.pitch, cfg.low_level, tol1)
			&& thr_low
			&& sga_pkg::near_lvl(item.roll, cfg.high_level, tol1);
		gest.run_ok  = mid3 && (thr_x > low_x + tol5_x);
		gest.idle_ok = mid3_wide && (thr_x < low_x + tol_x);
	end

endmodule

### sv/sga_mode_fsm.sv
`timescale 1ns / 1ps
// Mode controller: mode, prepared flag and the two saturating counters, plus result valid.
module sga_mode_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  sga_pkg::gest_t                    gest,
	input  sga_pkg::cfg_t                     cfg,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [sga_pkg::MODE_W-1:0]        mode,
	output logic                              prepared
);

	sga_pkg::mode_t mode_q;
	sga_pkg::mode_t mode_d;
	logic prep_q;
	logic prep_d;
	logic [sga_pkg::CNT_W-1:0] gcnt_q;
	logic [sga_pkg::CNT_W-1:0] gcnt_d;
	logic [sga_pkg::CNT_W-1:0] icnt_q;
	logic [sga_pkg::CNT_W-1:0] icnt_d;
	logic out_valid_q;

	always_comb begin
		mode_d = mode_q;
		prep_d = prep_q;
		gcnt_d = gcnt_q;
		icnt_d = icnt_q;
		case (mode_q)
			sga_pkg::MODE_INIT: begin
				if (gest.centered && gest.sw_ok) begin
					prep_d = 1'b1;
				end
				if (gest.gesture && gest.sw_ok) begin
					gcnt_d = sga_pkg::sat_inc(gcnt_q);
					if ((gcnt_d >= cfg.arm_dwell) && prep_d) begin
						mode_d = sga_pkg::MODE_STANDBY;
						gcnt_d = '0;
						prep_d = 1'b0;
					end
				end
			end
			sga_pkg::MODE_STANDBY: begin
				// The checks below run in order and each sees what the earlier ones left.
				if (gest.centered) begin
					prep_d = 1'b1;
				end
				if (gest.run_ok && gest.sw_ok && prep_d) begin
					mode_d = sga_pkg::MODE_RUNNING;
					gcnt_d = '0;
					prep_d = 1'b0;
				end
				if (gest.gesture) begin
					gcnt_d = sga_pkg::sat_inc(gcnt_d);
					if ((gcnt_d >= cfg.arm_dwell) && prep_d) begin
						mode_d = sga_pkg::MODE_INIT;
						gcnt_d = '0;
						prep_d = 1'b0;
					end
				end else begin
					gcnt_d = '0;
				end
				if (gest.idle_ok) begin
					icnt_d = sga_pkg::sat_inc(icnt_q);
					if (icnt_d >= cfg.idle_timeout) begin
						mode_d = sga_pkg::MODE_INIT;
						icnt_d = '0;
						gcnt_d = '0;
						prep_d = 1'b0;
					end
				end else begin
					icnt_d = '0;
				end
			end
			sga_pkg::MODE_RUNNING: begin
				if (gest.gesture) begin
					gcnt_d = sga_pkg::sat_inc(gcnt_q);
				end else begin
					gcnt_d = '0;
				end
				if (gcnt_d > cfg.run_disarm) begin
					mode_d = sga_pkg::MODE_INIT;
					gcnt_d = '0;
				end
			end
			default: begin
				mode_d = sga_pkg::MODE_INIT;
			end
		endcase
	end

	// The state registers double as the result register: the result is the state after the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sga_pkg::MODE_INIT;
			prep_q      <= 1'b0;
			gcnt_q      <= '0;
			icnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				mode_q      <= mode_d;
				prep_q      <= prep_d;
				gcnt_q      <= gcnt_d;
				icnt_q      <= icnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign mode      = mode_q;
	assign prepared  = prep_q;

endmodule

### sv/stick_gesture_arming_fsm_core.sv
`timescale 1ns / 1ps
// Top level of the stick gesture arming state machine.
// This block is the arm/disarm controller of a radio-controlled craft. Each item on the
// input channel is one control tick: four normalized stick values (signed, 1024 for 1.0)
// and four switch positions. For every item the block returns exactly one result, the
// mode after that tick (0 init, 1 standby, 2 running) and the prepared flag. An accepted
// item is held in an input register, the window comparisons and the mode update are done
// in a single short combinational pass, and the new state is captured in the state
// registers, which are also the result register. The result is valid once the state
// registers have captured it, which waits while the previous result is not taken. One
// item can be accepted every clock cycle while each result is taken when offered; the rate
// is set by the state update, since each tick depends on the state the previous tick left.
// The input stage keeps accepting while a result waits, as long as the waiting result is
// taken in the same cycle. The configuration registers (levels, tolerance and tick counts)
// are written through a plain write port with a register index; indexes beyond the last
// register are ignored. Write them only while no item is in flight.
module stick_gesture_arming_fsm_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sga_in_if.sink                               in_ch,
	sga_out_if.source                            out_ch,
	input  logic                                 cfg_we,
	input  logic [sga_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sga_pkg::CFG_W-1:0]            cfg_data
);

	sga_pkg::cfg_t  cfg_q;
	sga_pkg::item_t item_s1;
	logic           valid_s1;
	sga_pkg::gest_t gest;
	logic           out_valid;
	logic           step;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_level    <= -12'sd1024;
			cfg_q.center_level <= 12'sd0;
			cfg_q.high_level   <= 12'sd1024;
			cfg_q.tolerance    <= 11'd51;
			cfg_q.arm_dwell    <= 16'd200;
			cfg_q.run_disarm   <= 16'd100;
			cfg_q.idle_timeout <= 16'd1200;
		end else if (cfg_we) begin
			case (cfg_index)
				sga_pkg::CFG_LOW_LEVEL:    cfg_q.low_level    <= signed'(cfg_data[11:0]);
				sga_pkg::CFG_CENTER_LEVEL: cfg_q.center_level <= signed'(cfg_data[11:0]);
				sga_pkg::CFG_HIGH_LEVEL:   cfg_q.high_level   <= signed'(cfg_data[11:0]);
				sga_pkg::CFG_TOLERANCE:    cfg_q.tolerance    <= cfg_data[10:0];
				sga_pkg::CFG_ARM_DWELL:    cfg_q.arm_dwell    <= cfg_data;
				sga_pkg::CFG_RUN_DISARM:   cfg_q.run_disarm   <= cfg_data;
				sga_pkg::CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The registered item is processed when the result register is free or being emptied.
	assign step         = valid_s1 && (!out_valid || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.yaw      <= in_ch.yaw_stick;
			item_s1.roll     <= in_ch.roll_stick;
			item_s1.pitch    <= in_ch.pitch_stick;
			item_s1.throttle <= in_ch.throttle_stick;
			item_s1.sw_a     <= in_ch.switch_a_pos;
			item_s1.sw_b     <= in_ch.switch_b_pos;
			item_s1.sw_c     <= in_ch.switch_c_pos;
			item_s1.sw_d     <= in_ch.switch_d_pos;
		end
	end

	sga_gesture_dec u_dec (
		.item (item_s1),
		.cfg  (cfg_q),
		.gest (gest)
	);

	sga_mode_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.gest      (gest),
		.cfg       (cfg_q),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.mode      (out_ch.system_mode),
		.prepared  (out_ch.prepared_flag)
	);

	assign out_ch.valid = out_valid;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stick gesture arming state machine with a built-in mode predictor.
module tb_top;
	import sga_pkg::*;

	// Register index that decodes to nothing; writes to it must leave every setting alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	// Switch codes that count as an "other" position.
	localparam logic [SW_W-1:0] SW_MID = 2'd1;
	localparam logic [SW_W-1:0] SW_ODD = 2'd3;
	// Cycles without any item moving on either channel before the run is declared hung.
	localparam int WATCHDOG_CYCLES = 2000;

	typedef enum int {POSE_CENTER, POSE_ARM, POSE_RUN, POSE_IDLE, POSE_EDGE, POSE_WILD} pose_e;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              prepared;
	} mode_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sga_in_if in_ch();
	sga_out_if out_ch();

	stick_gesture_arming_fsm_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted state of the arming machine and our copy of its settings. The settings are
	// only changed while nothing is in flight, so the copy always matches what the block uses.
	mode_t fsm_mode = MODE_INIT;
	logic  fsm_prepared = 1'b0;
	int    gest_cnt = 0;
	int    idle_cnt = 0;
	cfg_t  fsm_cfg;

	mode_result_t expected_modes[$];
	int ticks_sent = 0;
	int ticks_done = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	// Chance in percent, per item or per cycle, that an idle burst starts on each side.
	int gap_pct = 0;
	int stall_pct = 0;

	function automatic cfg_t cfg_of(input int lo, input int ce, input int hi, input int tol,
			input int dwell, input int rdis, input int idle);
		cfg_t c;
		c.low_level    = lo[STICK_W-1:0];
		c.center_level = ce[STICK_W-1:0];
		c.high_level   = hi[STICK_W-1:0];
		c.tolerance    = tol[TOL_W-1:0];
		c.arm_dwell    = dwell[CNT_W-1:0];
		c.run_disarm   = rdis[CNT_W-1:0];
		c.idle_timeout = idle[CNT_W-1:0];
		return c;
	endfunction

	// Strict window test: the value must lie inside lvl - w .. lvl + w, ends excluded.
	function automatic bit in_window(input int v, input int lvl, input int w);
		return v < lvl + w && v > lvl - w;
	endfunction

	// Counters stop at the top of their 16-bit range instead of wrapping.
	function automatic int bump(input int c);
		return (c >= int'(CNT_MAX)) ? int'(CNT_MAX) : c + 1;
	endfunction

	// Advances the predicted machine by one control tick and returns the result it must show.
	function automatic void predict_tick(input item_t it, output logic [MODE_W-1:0] mode_o,
			output logic prep_o);
		int y;
		int ro;
		int p;
		int th;
		int lo;
		int ce;
		int hi;
		int t;
		bit sw_ok;
		bit mid3;
		bit centered;
		bit arm_pose;
		bit loose3;
		y  = int'($signed(it.yaw));
		ro = int'($signed(it.roll));
		p  = int'($signed(it.pitch));
		th = int'($signed(it.throttle));
		lo = int'($signed(fsm_cfg.low_level));
		ce = int'($signed(fsm_cfg.center_level));
		hi = int'($signed(fsm_cfg.high_level));
		t  = int'(fsm_cfg.tolerance);
		sw_ok = (it.sw_a == SW_MIN || it.sw_a == SW_MAX) && it.sw_b == SW_MIN &&
			it.sw_c == SW_MIN && it.sw_d == SW_MIN;
		mid3 = in_window(y, ce, t) && in_window(ro, ce, t) && in_window(p, ce, t);
		centered = mid3 && in_window(th, lo, t);
		arm_pose = in_window(y, lo, t) && in_window(p, lo, t) && in_window(th, lo, t) &&
			in_window(ro, hi, t);
		loose3 = in_window(y, ce, 3 * t) && in_window(ro, ce, 3 * t) &&
			in_window(p, ce, 3 * t);
		case (fsm_mode)
			MODE_INIT: begin
				if (centered && sw_ok)
					fsm_prepared = 1'b1;
				// A broken gesture leaves the count where it was in this mode.
				if (arm_pose && sw_ok) begin
					gest_cnt = bump(gest_cnt);
					if (gest_cnt >= int'(fsm_cfg.arm_dwell) && fsm_prepared) begin
						fsm_mode = MODE_STANDBY;
						gest_cnt = 0;
						fsm_prepared = 1'b0;
					end
				end
			end
			MODE_STANDBY: begin
				// The four checks run in order and each sees what the one before it left.
				if (centered)
					fsm_prepared = 1'b1;
				if (mid3 && th > lo + 5 * t && sw_ok && fsm_prepared) begin
					fsm_mode = MODE_RUNNING;
					gest_cnt = 0;
					fsm_prepared = 1'b0;
				end
				if (arm_pose) begin
					gest_cnt = bump(gest_cnt);
					if (gest_cnt >= int'(fsm_cfg.arm_dwell) && fsm_prepared) begin
						fsm_mode = MODE_INIT;
						gest_cnt = 0;
						fsm_prepared = 1'b0;
					end
				end else begin
					gest_cnt = 0;
				end
				if (loose3 && th < lo + t) begin
					idle_cnt = bump(idle_cnt);
					if (idle_cnt >= int'(fsm_cfg.idle_timeout)) begin
						fsm_mode = MODE_INIT;
						idle_cnt = 0;
						gest_cnt = 0;
						fsm_prepared = 1'b0;
					end
				end else begin
					idle_cnt = 0;
				end
			end
			MODE_RUNNING: begin
				if (arm_pose)
					gest_cnt = bump(gest_cnt);
				else
					gest_cnt = 0;
				if (gest_cnt > int'(fsm_cfg.run_disarm)) begin
					fsm_mode = MODE_INIT;
					gest_cnt = 0;
				end
			end
			default: begin
				fsm_mode = MODE_INIT;
			end
		endcase
		mode_o = fsm_mode;
		prep_o = fsm_prepared;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Clamps to the legal stick range of -1.0 .. +1.0.
	function automatic logic signed [STICK_W-1:0] to_stick(input int v);
		if (v < -1024)
			v = -1024;
		if (v > 1024)
			v = 1024;
		return v[STICK_W-1:0];
	endfunction

	// A value strictly inside the window around lvl when w is positive, so the window test then passes.
	function automatic logic signed [STICK_W-1:0] near_pick(input int lvl, input int w);
		if (w <= 1)
			return to_stick(lvl);
		return to_stick(lvl + int'($urandom_range(0, 2 * w - 2)) - (w - 1));
	endfunction

	// A value on or right beside the border of one of the windows the machine tests.
	function automatic logic signed [STICK_W-1:0] edge_pick(input int lo, input int ce,
			input int hi, input int t);
		int lvl;
		int w;
		int delta;
		case ($urandom_range(0, 2))
			0: lvl = lo;
			1: lvl = ce;
			default: lvl = hi;
		endcase
		w = t * (1 + 2 * int'($urandom_range(0, 2)));
		delta = w + int'($urandom_range(0, 2)) - 1;
		return to_stick($urandom_range(0, 1) ? lvl + delta : lvl - delta);
	endfunction

	function automatic item_t stick_tick(input int y, input int r, input int p, input int th,
			input logic [SW_W-1:0] a, input logic [SW_W-1:0] b, input logic [SW_W-1:0] c,
			input logic [SW_W-1:0] d);
		item_t it;
		it.yaw = to_stick(y);
		it.roll = to_stick(r);
		it.pitch = to_stick(p);
		it.throttle = to_stick(th);
		it.sw_a = a;
		it.sw_b = b;
		it.sw_c = c;
		it.sw_d = d;
		return it;
	endfunction

	// Builds one tick of the given stick pose around the current levels. With clean_sw set the
	// switches always allow arming; otherwise they sometimes take any code, the unused one too.
	function automatic item_t make_pose(input pose_e pose, input bit clean_sw);
		item_t it;
		int lo;
		int ce;
		int hi;
		int t;
		lo = int'($signed(fsm_cfg.low_level));
		ce = int'($signed(fsm_cfg.center_level));
		hi = int'($signed(fsm_cfg.high_level));
		t  = int'(fsm_cfg.tolerance);
		case (pose)
			POSE_CENTER: begin
				it.yaw = near_pick(ce, t);
				it.roll = near_pick(ce, t);
				it.pitch = near_pick(ce, t);
				it.throttle = near_pick(lo, t);
			end
			POSE_ARM: begin
				it.yaw = near_pick(lo, t);
				it.roll = near_pick(hi, t);
				it.pitch = near_pick(lo, t);
				it.throttle = near_pick(lo, t);
			end
			POSE_RUN: begin
				it.yaw = near_pick(ce, t);
				it.roll = near_pick(ce, t);
				it.pitch = near_pick(ce, t);
				it.throttle = to_stick(lo + 5 * t + 1 + int'($urandom_range(0, 300)));
			end
			POSE_IDLE: begin
				it.yaw = near_pick(ce, 3 * t);
				it.roll = near_pick(ce, 3 * t);
				it.pitch = near_pick(ce, 3 * t);
				it.throttle = to_stick(lo + t - 1 - int'($urandom_range(0, 150)));
			end
			POSE_EDGE: begin
				it.yaw = edge_pick(lo, ce, hi, t);
				it.roll = edge_pick(lo, ce, hi, t);
				it.pitch = edge_pick(lo, ce, hi, t);
				it.throttle = edge_pick(lo, ce, hi, t);
			end
			default: begin
				it.yaw = to_stick(int'($urandom_range(0, 2048)) - 1024);
				it.roll = to_stick(int'($urandom_range(0, 2048)) - 1024);
				it.pitch = to_stick(int'($urandom_range(0, 2048)) - 1024);
				it.throttle = to_stick(int'($urandom_range(0, 2048)) - 1024);
			end
		endcase
		if (clean_sw || $urandom_range(0, 7) != 0) begin
			it.sw_a = $urandom_range(0, 1) ? SW_MAX : SW_MIN;
			it.sw_b = SW_MIN;
			it.sw_c = SW_MIN;
			it.sw_d = SW_MIN;
		end else begin
			it.sw_a = SW_W'($urandom_range(0, 3));
			it.sw_b = SW_W'($urandom_range(0, 3));
			it.sw_c = SW_W'($urandom_range(0, 3));
			it.sw_d = SW_W'($urandom_range(0, 3));
		end
		return it;
	endfunction

	// Offers one item and returns at the clock edge where it is taken. Valid stays high into
	// the next call, which drops it only when it opens an idle burst.
	task automatic send_tick(input item_t it);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.yaw_stick <= it.yaw;
		in_ch.roll_stick <= it.roll;
		in_ch.pitch_stick <= it.pitch;
		in_ch.throttle_stick <= it.throttle;
		in_ch.switch_a_pos <= it.sw_a;
		in_ch.switch_b_pos <= it.sw_b;
		in_ch.switch_c_pos <= it.sw_c;
		in_ch.switch_d_pos <= it.sw_d;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		ticks_sent++;
	endtask

	// Stops offering items and waits until every accepted item has produced its result.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (ticks_done < ticks_sent) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes all seven settings plus one write to the unused index, which must change nothing.
	// Only called with the block idle, so the predictor can take the new values at once.
	task automatic set_config(input cfg_t c);
		fsm_cfg = c;
		put_reg(CFG_LOW_LEVEL, CFG_W'(c.low_level));
		put_reg(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
		put_reg(CFG_CENTER_LEVEL, CFG_W'(c.center_level));
		put_reg(CFG_HIGH_LEVEL, CFG_W'(c.high_level));
		put_reg(CFG_TOLERANCE, CFG_W'(c.tolerance));
		put_reg(CFG_ARM_DWELL, c.arm_dwell);
		put_reg(CFG_RUN_DISARM, c.run_disarm);
		put_reg(CFG_IDLE_TIMEOUT, c.idle_timeout);
		cfg_we <= 1'b0;
	endtask

	// One random phase: stick poses held for random stretches, on the arming and idle poses up
	// to just past the dwell and timeout counts, capped at 250, so the machine can walk its modes.
	task automatic run_phase(input cfg_t c, input int n_ticks, input int gap, input int stall);
		int sent_here;
		int pick;
		int cap;
		int len;
		pose_e pose;
		settle();
		set_config(c);
		gap_pct = gap;
		stall_pct = stall;
		sent_here = 0;
		while (sent_here < n_ticks) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				pose = POSE_ARM;
			else if (pick < 52)
				pose = POSE_CENTER;
			else if (pick < 72)
				pose = POSE_RUN;
			else if (pick < 87)
				pose = POSE_IDLE;
			else if (pick < 94)
				pose = POSE_EDGE;
			else
				pose = POSE_WILD;
			case (pose)
				POSE_ARM: cap = ((fsm_cfg.arm_dwell > fsm_cfg.run_disarm) ?
					int'(fsm_cfg.arm_dwell) : int'(fsm_cfg.run_disarm)) + 3;
				POSE_IDLE: cap = int'(fsm_cfg.idle_timeout) + 3;
				default: cap = 4;
			endcase
			if (cap > 250)
				cap = 250;
			len = $urandom_range(1, cap);
			if (len > n_ticks - sent_here)
				len = n_ticks - sent_here;
			repeat (len) send_tick(make_pose(pose, 1'b0));
			sent_here += len;
		end
	endtask

	// In init a broken arming gesture leaves the count alone. The dwell count is built up
	// partly around breaks and without the prepared flag; then one centered tick prepares and
	// a single further gesture arms. A count that cleared on each break would stay in init.
	task automatic test_init_count_kept();
		settle();
		set_config(cfg_of(-1024, 0, 1024, 51, 40, 100, 1200));
		gap_pct = 0;
		stall_pct = 0;
		repeat (20) begin
			send_tick(make_pose(POSE_ARM, 1'b1));
			send_tick(make_pose(POSE_RUN, 1'b1));
		end
		repeat (20) send_tick(make_pose(POSE_ARM, 1'b1));
		send_tick(make_pose(POSE_CENTER, 1'b1));
		send_tick(make_pose(POSE_ARM, 1'b1));
	endtask

	// Short hand-built walk: full-scale sticks, the unused switch code on every switch, one
	// pass through arming, running and disarm, and values right on the borders.
	task automatic test_gesture_walk();
		int lo;
		int hi;
		int t;
		lo = -1024;
		hi = 1024;
		t = 51;
		settle();
		set_config(cfg_of(lo, 0, hi, t, 2, 1, 3));
		gap_pct = 25;
		stall_pct = 6;
		send_tick(stick_tick(lo, lo, lo, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(hi, hi, hi, hi, SW_MAX, SW_MAX, SW_MAX, SW_MAX));
		// Centered sticks with clean switches set the prepared flag in init.
		repeat (3) send_tick(stick_tick(0, 0, 0, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		// Centered sticks with a switch in an other position leave the flag as it is.
		send_tick(stick_tick(0, 0, 0, lo, SW_ODD, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo, SW_MAX, SW_ODD, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo, SW_MIN, SW_MIN, SW_ODD, SW_MID));
		send_tick(stick_tick(0, 0, 0, lo, SW_MID, SW_MIN, SW_MIN, SW_ODD));
		send_tick(stick_tick(0, 0, 0, lo, SW_MAX, SW_MIN, SW_MIN, SW_MIN));
		repeat (2) send_tick(stick_tick(lo, hi, lo, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, 0, SW_MAX, SW_MIN, SW_MIN, SW_MIN));
		repeat (2) send_tick(stick_tick(lo, hi, lo, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		// Border values: exactly level plus or minus tolerance is outside the window.
		send_tick(stick_tick(t, 0, 0, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(t - 1, 0, 1 - t, lo + t - 1, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo + t, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(lo, hi - t, lo, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(lo + t - 1, hi - t + 1, lo, lo, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo + 5 * t, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
		send_tick(stick_tick(0, 0, 0, lo + 5 * t + 1, SW_MIN, SW_MIN, SW_MIN, SW_MIN));
	endtask

	// Random phases over a spread of settings: nominal, tolerance zero and 1024, random
	// levels, inverted levels with all tick counts at zero, the reset values, and the run
	// disarm and idle counts at their maximum.
	task automatic test_random_phases();
		run_phase(cfg_of(-1024, 0, 1024, 51, 4, 3, 6), 180, 12, 4);
		run_phase(cfg_of(-1024, 0, 1024, 0, 3, 2, 3), 180, 0, 0);
		run_phase(cfg_of(-1024, 0, 1024, 1024, 2, 1, 4), 180, 30, 10);
		run_phase(cfg_of(-300 - int'($urandom_range(0, 724)), int'($urandom_range(0, 400)) - 200,
			300 + int'($urandom_range(0, 724)), 1 + int'($urandom_range(0, 120)),
			1 + int'($urandom_range(0, 11)), $urandom_range(0, 10),
			1 + int'($urandom_range(0, 14))), 180, 5, 15);
		run_phase(cfg_of(1024, -1024, -1024, 200, 0, 0, 0), 180, 20, 0);
		run_phase(cfg_of(-1024, 0, 1024, 51, 200, 100, 1200), 400, 3, 3);
		run_phase(cfg_of(-1024, 0, 1024, 51, 5, 65535, 65535), 180, 0, 20);
	endtask

	// Back-to-back traffic with the receiver always ready, to close the run.
	task automatic test_full_rate_tail();
		run_phase(cfg_of(-900 + int'($urandom_range(0, 200)), int'($urandom_range(0, 100)) - 50,
			800 + int'($urandom_range(0, 224)), 20 + int'($urandom_range(0, 60)),
			1 + int'($urandom_range(0, 5)), $urandom_range(0, 4),
			1 + int'($urandom_range(0, 6))), 180, 0, 0);
	endtask

	// Receiver side: ready drops for random bursts while stall_pct is nonzero.
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Scoreboard: a result is matched against the oldest pending prediction before the item
	// taken at the same edge is predicted, so a result can never match its own item. Both
	// channels are sampled at the rising edge, before any new value driven there settles.
	always @(posedge clk) begin : scoreboard
		item_t seen;
		mode_result_t want;
		logic [MODE_W-1:0] next_mode;
		logic next_prep;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_modes.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with no tick pending",
						ticks_done));
				end else begin
					want = expected_modes.pop_front();
					if (out_ch.system_mode !== want.mode)
						flag_mismatch($sformatf("tick %0d system_mode %0d, predicted %0d",
							ticks_done, out_ch.system_mode, want.mode));
					if (out_ch.prepared_flag !== want.prepared)
						flag_mismatch($sformatf("tick %0d prepared_flag %0b, predicted %0b",
							ticks_done, out_ch.prepared_flag, want.prepared));
				end
				ticks_done++;
			end
			if (in_ch.valid && in_ch.ready) begin
				seen.yaw = in_ch.yaw_stick;
				seen.roll = in_ch.roll_stick;
				seen.pitch = in_ch.pitch_stick;
				seen.throttle = in_ch.throttle_stick;
				seen.sw_a = in_ch.switch_a_pos;
				seen.sw_b = in_ch.switch_b_pos;
				seen.sw_c = in_ch.switch_c_pos;
				seen.sw_d = in_ch.switch_d_pos;
				predict_tick(seen, next_mode, next_prep);
				want.mode = next_mode;
				want.prepared = next_prep;
				expected_modes.push_back(want);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		fsm_cfg = cfg_of(-1024, 0, 1024, 51, 200, 100, 1200);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOW_LEVEL;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.yaw_stick = '0;
		in_ch.roll_stick = '0;
		in_ch.pitch_stick = '0;
		in_ch.throttle_stick = '0;
		in_ch.switch_a_pos = SW_MIN;
		in_ch.switch_b_pos = SW_MIN;
		in_ch.switch_c_pos = SW_MIN;
		in_ch.switch_d_pos = SW_MIN;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_init_count_kept();
		test_gesture_walk();
		test_random_phases();
		test_full_rate_tail();

		// Everything is in; let the last results drain, then keep watching for any stray result
		// to show up.
		settle();
		repeat (8) @(posedge clk);
		if (expected_modes.size() != 0)
			flag_mismatch($sformatf("%0d predicted results never arrived",
				expected_modes.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
sv/sga_pkg.sv
sv/sga_if.sv
sv/sga_gesture_dec.sv
sv/sga_mode_fsm.sv
sv/stick_gesture_arming_fsm_core.sv
tb/sv/tb_top.sv
